@@ src/coo_to_csr_tile_converter_macros.svh @@
// ---------------------------------------------------------------------------
// COO to CSR tile converter assertion macros
// Shared assertion shorthands, all sampled on clk and quiet during rst.
// ---------------------------------------------------------------------------
`ifndef COO_TO_CSR_TILE_CONVERTER_MACROS_SVH
`define COO_TO_CSR_TILE_CONVERTER_MACROS_SVH

// check that a property holds
`define CTTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that a condition never occurs
`define CTTC_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

@@ src/cttc_pkg.sv @@
// ---------------------------------------------------------------------------
// cttc_pkg
// Shared types and constants of the COO to CSR tile converter.
// ---------------------------------------------------------------------------
package cttc_pkg;

  localparam int MAX_ROWS_DEF = 128;
  localparam int MAX_NNZ_DEF  = 4096;

  localparam int CMD_W  = 3;
  localparam int ROW_W  = 15;
  localparam int COL_W  = 15;
  localparam int VAL_W  = 16;
  localparam int IDX_W  = 13;
  localparam int STAT_W = 2;
  localparam int DA_W   = 15;
  localparam int CNT_W  = 13;
  localparam int OFF_W  = 15;
  localparam int TR_W   = 8;
  localparam int CFG_W  = 15;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR    = 3'd0,
    CMD_LOAD     = 3'd1,
    CMD_BUILD    = 3'd2,
    CMD_READ_PTR = 3'd3,
    CMD_READ_ENT = 3'd4
  } cttc_cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_ROW_DROP  = 2'd1,
    STAT_FULL_DROP = 2'd2,
    STAT_INVALID   = 2'd3
  } cttc_status_t;

  typedef enum logic {
    REG_FIRST_ROW    = 1'b0,
    REG_ROWS_IN_TILE = 1'b1
  } cttc_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ_PTR,
    S_READ_ENT,
    S_ZERO,
    S_CNT_A,
    S_CNT_B,
    S_CNT_C,
    S_PFX_A,
    S_PFX_B,
    S_SCT_A,
    S_SCT_B,
    S_SCT_C
  } cttc_state_t;

  typedef struct packed {
    cttc_cmd_t                cmd;
    logic [ROW_W-1:0]         row;
    logic [COL_W-1:0]         col;
    logic signed [VAL_W-1:0]  value;
    logic [IDX_W-1:0]         index;
  } cttc_req_t;

  typedef struct packed {
    cttc_status_t             status;
    logic [DA_W-1:0]          data_a;
    logic signed [VAL_W-1:0]  data_b;
    logic [CNT_W-1:0]         count;
  } cttc_resp_t;

endpackage

@@ src/cttc_ram.sv @@
// ---------------------------------------------------------------------------
// cttc_ram
// Single-port RAM, one write or read per cycle, registered read data.
// ---------------------------------------------------------------------------
module cttc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ src/cttc_core.sv @@
// ---------------------------------------------------------------------------
// cttc_core
// Element stores, CSR stores and the sequencer that runs every command,
// including the multi-pass build over the row pointer and fill count RAMs.
// ---------------------------------------------------------------------------
module cttc_core import cttc_pkg::*; #(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_NNZ  = MAX_NNZ_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  cttc_req_t        req,
  input  logic [OFF_W-1:0] first_row,
  input  logic [TR_W-1:0]  rows_in_tile,
  output logic             idle,
  output logic             resp_valid,
  output cttc_resp_t       resp
);

  localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int RPW = $clog2(MAX_ROWS + 1);
  localparam int AW  = $clog2(MAX_NNZ);
  localparam int ECW = $clog2(MAX_NNZ + 1);

  cttc_state_t state, state_next;
  logic [ECW-1:0]   ec, ec_next;
  logic             built, built_next;
  logic [RPW-1:0]   built_rows, built_rows_next;
  logic [ECW-1:0]   total, total_next;
  logic [RPW-1:0]   rows_b, rows_b_next;
  logic [ECW-1:0]   cnt_i, cnt_i_next;
  logic [RPW:0]     cnt_k, cnt_k_next;
  logic [ECW-1:0]   acc, acc_next;
  logic [RW-1:0]    rel, rel_next;
  logic [COL_W-1:0] col_hold, col_hold_next;
  logic [VAL_W-1:0] val_hold, val_hold_next;

  logic             coo_we;
  logic [AW-1:0]    coo_addr;
  logic [RW-1:0]    coo_row_wd, coo_row_q;
  logic [COL_W-1:0] coo_col_wd, coo_col_q;
  logic [VAL_W-1:0] coo_val_wd, coo_val_q;
  logic             csr_we;
  logic [AW-1:0]    csr_addr;
  logic [COL_W-1:0] csr_col_q;
  logic [VAL_W-1:0] csr_val_q;
  logic             rp_we;
  logic [RPW-1:0]   rp_addr;
  logic [ECW-1:0]   rp_wd, rp_q;
  logic             fc_we;
  logic [RW-1:0]    fc_addr;
  logic [ECW-1:0]   fc_wd, fc_q;

  logic [RPW-1:0]   tr;
  logic [ROW_W-1:0] diff;
  logic [31:0]      idx32, rp_q32, ec_next32;
  logic [ECW-1:0]   dest;
  logic             row_in_b;

  cttc_ram #(.WIDTH(RW),    .DEPTH(MAX_NNZ)) u_coo_row (
    .clk, .we(coo_we), .addr(coo_addr), .wdata(coo_row_wd), .rdata(coo_row_q));
  cttc_ram #(.WIDTH(COL_W), .DEPTH(MAX_NNZ)) u_coo_col (
    .clk, .we(coo_we), .addr(coo_addr), .wdata(coo_col_wd), .rdata(coo_col_q));
  cttc_ram #(.WIDTH(VAL_W), .DEPTH(MAX_NNZ)) u_coo_val (
    .clk, .we(coo_we), .addr(coo_addr), .wdata(coo_val_wd), .rdata(coo_val_q));
  cttc_ram #(.WIDTH(COL_W), .DEPTH(MAX_NNZ)) u_csr_col (
    .clk, .we(csr_we), .addr(csr_addr), .wdata(col_hold), .rdata(csr_col_q));
  cttc_ram #(.WIDTH(VAL_W), .DEPTH(MAX_NNZ)) u_csr_val (
    .clk, .we(csr_we), .addr(csr_addr), .wdata(val_hold), .rdata(csr_val_q));
  cttc_ram #(.WIDTH(ECW), .DEPTH(MAX_ROWS + 1)) u_row_ptr (
    .clk, .we(rp_we), .addr(rp_addr), .wdata(rp_wd), .rdata(rp_q));
  cttc_ram #(.WIDTH(ECW), .DEPTH(MAX_ROWS)) u_fill_cnt (
    .clk, .we(fc_we), .addr(fc_addr), .wdata(fc_wd), .rdata(fc_q));

  // saturate the tile row count
  always_comb begin
    if (32'(rows_in_tile) > MAX_ROWS) begin
      tr = RPW'(MAX_ROWS);
    end else begin
      tr = RPW'(rows_in_tile);
    end
  end

  assign diff      = req.row - first_row;
  assign idx32     = 32'(req.index);
  assign rp_q32    = 32'(rp_q);
  assign ec_next32 = 32'(ec_next);
  assign dest      = rp_q + fc_q;
  assign row_in_b  = RPW'(coo_row_q) < rows_b;
  assign idle      = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ec         <= '0;
      built      <= 1'b0;
      built_rows <= '0;
      total      <= '0;
    end else begin
      state      <= state_next;
      ec         <= ec_next;
      built      <= built_next;
      built_rows <= built_rows_next;
      total      <= total_next;
    end
  end

  always_ff @(posedge clk) begin
    rows_b   <= rows_b_next;
    cnt_i    <= cnt_i_next;
    cnt_k    <= cnt_k_next;
    acc      <= acc_next;
    rel      <= rel_next;
    col_hold <= col_hold_next;
    val_hold <= val_hold_next;
  end

  always_comb begin
    state_next      = state;
    ec_next         = ec;
    built_next      = built;
    built_rows_next = built_rows;
    total_next      = total;
    rows_b_next     = rows_b;
    cnt_i_next      = cnt_i;
    cnt_k_next      = cnt_k;
    acc_next        = acc;
    rel_next        = rel;
    col_hold_next   = col_hold;
    val_hold_next   = val_hold;
    coo_we          = 1'b0;
    coo_addr        = ec[AW-1:0];
    coo_row_wd      = diff[RW-1:0];
    coo_col_wd      = req.col;
    coo_val_wd      = req.value;
    csr_we          = 1'b0;
    csr_addr        = idx32[AW-1:0];
    rp_we           = 1'b0;
    rp_addr         = idx32[RPW-1:0];
    rp_wd           = '0;
    fc_we           = 1'b0;
    fc_addr         = rel;
    fc_wd           = '0;
    resp_valid      = 1'b0;
    resp.status     = STAT_OK;
    resp.data_a     = '0;
    resp.data_b     = '0;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          case (req.cmd)
            CMD_CLEAR: begin
              ec_next    = '0;
              built_next = 1'b0;
              resp_valid = 1'b1;
            end
            CMD_LOAD: begin
              resp_valid = 1'b1;
              if (req.row < first_row || 32'(diff) >= 32'(tr)) begin
                resp.status = STAT_ROW_DROP;
              end else if (32'(ec) >= MAX_NNZ) begin
                resp.status = STAT_FULL_DROP;
              end else begin
                coo_we     = 1'b1;
                ec_next    = ec + ECW'(1);
                built_next = 1'b0;
              end
            end
            CMD_BUILD: begin
              rows_b_next = tr;
              cnt_k_next  = '0;
              state_next  = S_ZERO;
            end
            CMD_READ_PTR: begin
              if (!built || idx32 > 32'(built_rows)) begin
                resp.status = STAT_INVALID;
                resp_valid  = 1'b1;
              end else begin
                state_next = S_READ_PTR;
              end
            end
            CMD_READ_ENT: begin
              if (!built || idx32 >= 32'(total) || idx32 >= MAX_NNZ) begin
                resp.status = STAT_INVALID;
                resp_valid  = 1'b1;
              end else begin
                state_next = S_READ_ENT;
              end
            end
            default: begin
              resp_valid = 1'b1;
            end
          endcase
        end
      end
      S_READ_PTR: begin
        resp.data_a = rp_q32[DA_W-1:0];
        resp_valid  = 1'b1;
        state_next  = S_IDLE;
      end
      S_READ_ENT: begin
        resp.data_a = csr_col_q;
        resp.data_b = csr_val_q;
        resp_valid  = 1'b1;
        state_next  = S_IDLE;
      end
      S_ZERO: begin
        rp_addr = cnt_k[RPW-1:0];
        rp_we   = 1'b1;
        fc_addr = cnt_k[RW-1:0];
        fc_we   = (cnt_k < {1'b0, rows_b});
        if (cnt_k == {1'b0, rows_b}) begin
          cnt_i_next = '0;
          state_next = S_CNT_A;
        end else begin
          cnt_k_next = cnt_k + (RPW+1)'(1);
        end
      end
      S_CNT_A: begin
        coo_addr = cnt_i[AW-1:0];
        if (cnt_i == ec) begin
          cnt_k_next = (RPW+1)'(1);
          acc_next   = '0;
          state_next = S_PFX_A;
        end else begin
          state_next = S_CNT_B;
        end
      end
      S_CNT_B: begin
        rp_addr = RPW'(coo_row_q) + RPW'(1);
        if (row_in_b) begin
          rel_next   = coo_row_q;
          state_next = S_CNT_C;
        end else begin
          cnt_i_next = cnt_i + ECW'(1);
          state_next = S_CNT_A;
        end
      end
      S_CNT_C: begin
        rp_addr    = RPW'(rel) + RPW'(1);
        rp_we      = 1'b1;
        rp_wd      = rp_q + ECW'(1);
        cnt_i_next = cnt_i + ECW'(1);
        state_next = S_CNT_A;
      end
      S_PFX_A: begin
        rp_addr = cnt_k[RPW-1:0];
        if (cnt_k > {1'b0, rows_b}) begin
          total_next = acc;
          cnt_i_next = '0;
          state_next = S_SCT_A;
        end else begin
          state_next = S_PFX_B;
        end
      end
      S_PFX_B: begin
        rp_addr    = cnt_k[RPW-1:0];
        rp_we      = 1'b1;
        rp_wd      = acc + rp_q;
        acc_next   = acc + rp_q;
        cnt_k_next = cnt_k + (RPW+1)'(1);
        state_next = S_PFX_A;
      end
      S_SCT_A: begin
        coo_addr = cnt_i[AW-1:0];
        if (cnt_i == ec) begin
          built_next      = 1'b1;
          built_rows_next = rows_b;
          resp_valid      = 1'b1;
          state_next      = S_IDLE;
        end else begin
          state_next = S_SCT_B;
        end
      end
      S_SCT_B: begin
        rp_addr = RPW'(coo_row_q);
        fc_addr = coo_row_q;
        if (row_in_b) begin
          rel_next      = coo_row_q;
          col_hold_next = coo_col_q;
          val_hold_next = coo_val_q;
          state_next    = S_SCT_C;
        end else begin
          cnt_i_next = cnt_i + ECW'(1);
          state_next = S_SCT_A;
        end
      end
      S_SCT_C: begin
        csr_addr   = dest[AW-1:0];
        csr_we     = 1'b1;
        fc_addr    = rel;
        fc_we      = 1'b1;
        fc_wd      = fc_q + ECW'(1);
        cnt_i_next = cnt_i + ECW'(1);
        state_next = S_SCT_A;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    resp.count = ec_next32[CNT_W-1:0];
  end

endmodule

@@ src/coo_to_csr_tile_converter.sv @@
// ---------------------------------------------------------------------------
// coo_to_csr_tile_converter
// Collects (row, col, value) elements of one matrix tile and rebuilds them
// in compressed sparse row form for indexed read-back.
// ---------------------------------------------------------------------------
// Each input word is one command and yields exactly one result word. Clear,
// load, unknown commands and rejected reads are answered from the idle
// state. Accepted reads pass through a read state, as the row pointer or
// CSR RAM has a registered read. A build runs a sequencer over single-port
// RAMs and keeps the sequencer busy, with in_ready low, from when the build
// word is taken until its result is given: a zeroing sweep over the row
// pointer and fill count RAMs, a counting pass (read, read-modify-write per
// element), a prefix-sum pass over the rows and a scatter pass over the
// elements. Elements keep their load order within each row. Loads outside
// [first_row, first_row + rows) or into a full store are dropped and
// flagged in status. Write the configuration registers only while the
// block is idle; reads keep the row count of the last build. The output
// register lets a new word enter in the cycle its predecessor's result is
// taken.
// ---------------------------------------------------------------------------
module coo_to_csr_tile_converter import cttc_pkg::*; #(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_NNZ  = MAX_NNZ_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [CMD_W-1:0]         command,
  input  logic [ROW_W-1:0]         row,
  input  logic [COL_W-1:0]         col,
  input  logic signed [VAL_W-1:0]  value,
  input  logic [IDX_W-1:0]         index,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [STAT_W-1:0]        status,
  output logic [DA_W-1:0]          data_a,
  output logic signed [VAL_W-1:0]  data_b,
  output logic [CNT_W-1:0]         count,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data
);

`include "coo_to_csr_tile_converter_macros.svh"

  logic [OFF_W-1:0] first_row;
  logic [TR_W-1:0]  rows_in_tile;
  logic             core_idle;
  logic             core_start;
  logic             resp_valid;
  cttc_req_t        req;
  cttc_resp_t       resp;
  cttc_resp_t       res_q;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      first_row    <= '0;
      rows_in_tile <= TR_W'(128);
    end else if (cfg_we) begin
      unique case (cttc_reg_t'(cfg_index))
        REG_FIRST_ROW:    first_row    <= cfg_data;
        REG_ROWS_IN_TILE: rows_in_tile <= cfg_data[TR_W-1:0];
        default: ;
      endcase
    end
  end

  // take a word when the sequencer is idle and the result slot frees up
  assign in_ready   = core_idle && (!out_valid || out_ready);
  assign core_start = in_valid && in_ready;

  assign req.cmd   = cttc_cmd_t'(command);
  assign req.row   = row;
  assign req.col   = col;
  assign req.value = value;
  assign req.index = index;

  cttc_core #(.MAX_ROWS(MAX_ROWS), .MAX_NNZ(MAX_NNZ)) u_core (
    .clk,
    .rst,
    .start        (core_start),
    .req          (req),
    .first_row    (first_row),
    .rows_in_tile (rows_in_tile),
    .idle         (core_idle),
    .resp_valid   (resp_valid),
    .resp         (resp)
  );

  // result register: load on a new result, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (resp_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (resp_valid) begin
      res_q <= resp;
    end
  end

  assign status = res_q.status;
  assign data_a = res_q.data_a;
  assign data_b = res_q.data_b;
  assign count  = res_q.count;

  `CTTC_NEVER(a_no_overwrite, resp_valid && out_valid && !out_ready, "result overwritten before taken")
  `CTTC_ASSERT(a_build_stalls, core_start && command == CMD_BUILD |=> !in_ready, "build did not stall input")
  `CTTC_NEVER(a_idle_result, resp_valid && !core_idle && core_start, "word taken while sequencer busy")

endmodule
